@@ rtl/apd_pkg.sv @@
// Package for the aligned periodic deadline unit: field widths, time constants,
// register indexes, operation codes and controller states. No dependencies.
package apd_pkg;

  localparam int unsigned SEC_W  = 32;
  localparam int unsigned NS_W   = 30;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [TIME_W-1:0] NS_PER_S = 64'd1000000000;
  localparam logic [NS_W-1:0]   NS_MAX   = 30'd999999999;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_DLY_S    = 3'd1,
    CFG_DLY_NS   = 3'd2,
    CFG_OFFSET   = 3'd3,
    CFG_IVL_S    = 3'd4,
    CFG_IVL_NS   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_ARM     = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ALIGN1,
    ST_ALIGN2,
    ST_ALIGN3,
    ST_GO,
    ST_MOD,
    ST_SPLIT
  } state_e;

  typedef enum logic [1:0] {
    DSEL_FWD,
    DSEL_BACK,
    DSEL_REST
  } div_sel_e;

  // Brings a sum of two nanosecond fields below one second. Each field is
  // below 2^30, so two conditional subtractions are always enough.
  function automatic logic [NS_W-1:0] norm_ns(input logic [NS_W:0] sum);
    logic [NS_W:0] t;
    t = sum;
    if (t >= NS_PER_S[NS_W:0]) t = t - NS_PER_S[NS_W:0];
    if (t >= NS_PER_S[NS_W:0]) t = t - NS_PER_S[NS_W:0];
    return t[NS_W-1:0];
  endfunction

endpackage

@@ rtl/apd_mul.sv @@
// Bit-serial multiplier: seconds times one billion plus nanoseconds, one bit of
// the seconds per cycle, most significant bit first. Depends on apd_pkg.
module apd_mul import apd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SEC_W-1:0]  sec_i,
  input  logic [NS_W-1:0]   ns_i,
  output logic              done_o,
  output logic [TIME_W-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(SEC_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SEC_W-1:0]  m_q, m_d;
  logic [NS_W-1:0]   ns_q, ns_d;
  logic [TIME_W-1:0] acc_q, acc_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    m_d    = m_q;
    ns_d   = ns_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      m_d    = sec_i;
      ns_d   = ns_i;
      acc_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == CntW'(SEC_W)) begin
        // All seconds bits are in; the last step adds the nanosecond part.
        acc_d  = acc_q + {{(TIME_W-NS_W){1'b0}}, ns_q};
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        acc_d = {acc_q[TIME_W-2:0], 1'b0} + (m_q[SEC_W-1] ? NS_PER_S : '0);
        m_d   = {m_q[SEC_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    ns_q  <= ns_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ rtl/apd_div.sv @@
// Restoring divider for 64-bit unsigned operands, one quotient bit per cycle.
// Done, quotient and remainder hold until the next start. Depends on apd_pkg.
module apd_div import apd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] dividend_i,
  input  logic [TIME_W-1:0] divisor_i,
  output logic              done_o,
  output logic [TIME_W-1:0] quot_o,
  output logic [TIME_W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(TIME_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TIME_W-1:0] q_q, q_d;
  logic [TIME_W-1:0] r_q, r_d;
  logic [TIME_W-1:0] d_q, d_d;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;

  assign trial = {r_q, q_q[TIME_W-1]};
  assign diff  = trial - {1'b0, d_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      q_d    = dividend_i;
      r_d    = '0;
      d_d    = divisor_i;
    end else if (busy_q) begin
      // The dividend shifts out of the top of q while quotient bits enter below.
      if (!diff[TIME_W]) begin
        r_d = diff[TIME_W-1:0];
        q_d = {q_q[TIME_W-2:0], 1'b1};
      end else begin
        r_d = trial[TIME_W-1:0];
        q_d = {q_q[TIME_W-2:0], 1'b0};
      end
      if (cnt_q == CntW'(TIME_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

@@ rtl/aligned_periodic_deadline_unit.sv @@
// Aligned periodic deadline unit, one item at a time: an arm transfer passes through the
// multiply, align and split steps, a timeout past the first firing through multiply, modulo
// and split, and one before it through multiply and split. A disabled or unarmed transfer
// goes straight to the output, a zero-period fault after the multiply. The input stalls
// until the result is loaded, so the next transfer comes in the cycle after the load at the earliest.
// Reset clears control, the armed flag and config, but the period's seconds reset to one.
module aligned_periodic_deadline_unit import apd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [SEC_W-1:0]  now_seconds_i,
  input  logic [NS_W-1:0]   now_nanoseconds_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SEC_W-1:0]  wait_seconds_o,
  output logic [NS_W-1:0]   wait_nanoseconds_o,
  output logic              armed_o,
  output logic              fault_o
);

  // Configuration and persistent state.
  logic              enable_q;
  logic [SEC_W-1:0]  dly_s_q;
  logic [NS_W-1:0]   dly_ns_q;
  logic [NS_W-1:0]   off_q;
  logic [SEC_W-1:0]  ivl_s_q;
  logic [NS_W-1:0]   ivl_ns_q;
  logic [TIME_W-1:0] fft_q;
  logic              armed_q;

  // Controller and working registers.
  state_e            state_q, state_d;
  op_e               op_q;
  logic [NS_W-1:0]   part_q;
  logic [TIME_W-1:0] tmp_q;
  logic              res_armed_q, res_fault_q, res_div_q;
  logic              out_valid_q;
  logic [SEC_W-1:0]  out_s_q;
  logic [NS_W-1:0]   out_ns_q;
  logic              out_armed_q, out_fault_q;

  // Control signals.
  logic              in_fire;
  logic              out_free;
  logic              mul_start;
  logic              div_start;
  div_sel_e          div_sel;
  logic              out_load;

  // Datapath signals.
  logic              mul_done_a, mul_done_b, mul_done;
  logic [TIME_W-1:0] now_p, per_p;
  logic [SEC_W-1:0]  mul_b_sec;
  logic [NS_W-1:0]   mul_b_ns;
  logic              div_done;
  logic [TIME_W-1:0] div_dividend, div_divisor, div_quot, div_rem;
  logic [NS_W:0]     fire_ns;
  logic              sat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mul_done   = mul_done_a & mul_done_b;

  // The second multiplier forms the delay on arm and the period on timeout.
  assign mul_b_sec = (op_e'(operation_i) == OP_ARM) ? dly_s_q  : ivl_s_q;
  assign mul_b_ns  = (op_e'(operation_i) == OP_ARM) ? dly_ns_q : ivl_ns_q;

  apd_mul u_mul_now (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .sec_i   (now_seconds_i),
    .ns_i    (now_nanoseconds_i),
    .done_o  (mul_done_a),
    .prod_o  (now_p)
  );

  apd_mul u_mul_span (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .sec_i   (mul_b_sec),
    .ns_i    (mul_b_ns),
    .done_o  (mul_done_b),
    .prod_o  (per_p)
  );

  always_comb begin
    unique case (div_sel)
      DSEL_FWD:  div_dividend = fft_q - now_p;
      DSEL_BACK: div_dividend = now_p - fft_q;
      DSEL_REST: div_dividend = per_p - div_rem;
      default:   div_dividend = fft_q - now_p;
    endcase
  end

  assign div_divisor = (div_sel == DSEL_BACK) ? per_p : NS_PER_S;

  apd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!enable_q) begin
            state_d = ST_GO;
          end else if (op_e'(operation_i) == OP_TIMEOUT && !armed_q) begin
            state_d = ST_GO;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (op_q == OP_ARM) begin
            state_d = ST_ALIGN1;
          end else if (now_p < fft_q) begin
            state_d = ST_GO;
          end else if (per_p == '0) begin
            state_d = ST_GO;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_ALIGN1: state_d = ST_ALIGN2;
      ST_ALIGN2: state_d = ST_ALIGN3;
      ST_ALIGN3: state_d = ST_GO;
      ST_GO: begin
        if (res_div_q) begin
          state_d = ST_SPLIT;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (div_done) state_d = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (div_done && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs. ST_GO either starts the split of a forward wait or, for a
  // result with no wait, hands it to the output register.
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    div_sel   = DSEL_FWD;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        mul_start = in_fire && enable_q &&
                    (op_e'(operation_i) == OP_ARM || armed_q);
      end
      ST_MUL: begin
        if (mul_done && op_q == OP_TIMEOUT && !(now_p < fft_q) && per_p != '0) begin
          div_start = 1'b1;
          div_sel   = DSEL_BACK;
        end
      end
      ST_GO: begin
        if (res_div_q) begin
          div_start = 1'b1;
          div_sel   = DSEL_FWD;
        end else begin
          out_load = out_free;
        end
      end
      ST_MOD: begin
        if (div_done) begin
          div_start = 1'b1;
          div_sel   = DSEL_REST;
        end
      end
      ST_SPLIT: begin
        out_load = div_done && out_free;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // The split result stays in the divider until the output register is free.
  // A quotient above 32 bits saturates both wait fields.
  assign sat     = (div_quot[TIME_W-1:SEC_W] != '0);
  assign fire_ns = {1'b0, off_q} + ((part_q > off_q) ? NS_PER_S[NS_W:0] : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      dly_s_q     <= '0;
      dly_ns_q    <= '0;
      off_q       <= '0;
      ivl_s_q     <= SEC_W'(1);
      ivl_ns_q    <= '0;
      armed_q     <= 1'b0;
      fft_q       <= '0;
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ENABLE: begin
            enable_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) armed_q <= 1'b0;
          end
          CFG_DLY_S:  dly_s_q  <= cfg_data_i;
          CFG_DLY_NS: dly_ns_q <= cfg_data_i[NS_W-1:0];
          CFG_OFFSET: off_q    <= cfg_data_i[NS_W-1:0];
          CFG_IVL_S:  ivl_s_q  <= cfg_data_i;
          CFG_IVL_NS: ivl_ns_q <= cfg_data_i[NS_W-1:0];
          default: begin
            enable_q <= enable_q;
          end
        endcase
      end
      if (in_fire && !enable_q) armed_q <= 1'b0;
      if (state_q == ST_ALIGN3) begin
        fft_q   <= tmp_q + {{(TIME_W-NS_W-1){1'b0}}, fire_ns};
        armed_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_e'(operation_i);
      // Arm only: the base time's part within its second.
      part_q <= norm_ns({1'b0, now_nanoseconds_i} + {1'b0, dly_ns_q});
      if (!enable_q) begin
        res_armed_q <= 1'b0;
        res_fault_q <= 1'b0;
        res_div_q   <= 1'b0;
      end else if (op_e'(operation_i) == OP_TIMEOUT && !armed_q) begin
        res_armed_q <= 1'b0;
        res_fault_q <= 1'b1;
        res_div_q   <= 1'b0;
      end else begin
        res_armed_q <= 1'b1;
        res_fault_q <= 1'b0;
        res_div_q   <= 1'b1;
      end
    end
    if (state_q == ST_MUL && mul_done && op_q == OP_TIMEOUT && !(now_p < fft_q) &&
        per_p == '0) begin
      res_fault_q <= 1'b1;
      res_div_q   <= 1'b0;
    end
    if (state_q == ST_ALIGN1) tmp_q <= now_p + per_p;
    if (state_q == ST_ALIGN2) tmp_q <= tmp_q - {{(TIME_W-NS_W){1'b0}}, part_q};
    if (out_load) begin
      out_armed_q <= res_armed_q;
      out_fault_q <= res_fault_q;
      if (!res_div_q) begin
        out_s_q  <= '0;
        out_ns_q <= '0;
      end else if (sat) begin
        out_s_q  <= SEC_MAX;
        out_ns_q <= NS_MAX;
      end else begin
        out_s_q  <= div_quot[SEC_W-1:0];
        out_ns_q <= div_rem[NS_W-1:0];
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign wait_seconds_o     = out_s_q;
  assign wait_nanoseconds_o = out_ns_q;
  assign armed_o            = out_armed_q;
  assign fault_o            = out_fault_q;

`ifndef SYNTHESIS
  // A new result appears only when the controller hands one over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_GO || state_q == ST_SPLIT))
    else $error("result appeared without a completed item");

  // Fault results never carry a wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_o) |-> (wait_seconds_o == '0 && wait_nanoseconds_o == '0))
    else $error("fault result with nonzero wait");

  // The split always leaves a nanosecond part below one second.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wait_nanoseconds_o <= NS_MAX))
    else $error("wait nanoseconds out of range");

  // An armed result can only come from an enabled timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && armed_o) |-> enable_q)
    else $error("armed result while disabled");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for aligned_periodic_deadline_unit: directed table, then random
// arm/timeout sequences under random idling, checked against an integer-nanosecond predictor.
// Depends on apd_pkg and the unit itself.
module tb_top import apd_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 2500000;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned QUIET_AFTER = 1750;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [SEC_W-1:0] wait_s;
    logic [NS_W-1:0]  wait_ns;
    logic             armed;
    logic             fault;
  } deadline_wait_t;

  typedef struct packed {
    logic             is_cfg;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
    op_e              op;
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
    logic             typed;
    deadline_wait_t   want;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             operation_i;
  logic [SEC_W-1:0] now_seconds_i;
  logic [NS_W-1:0]  now_nanoseconds_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [SEC_W-1:0] wait_seconds_o;
  logic [NS_W-1:0]  wait_nanoseconds_o;
  logic             armed_o;
  logic             fault_o;

  aligned_periodic_deadline_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .now_seconds_i      (now_seconds_i),
    .now_nanoseconds_i  (now_nanoseconds_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .wait_seconds_o     (wait_seconds_o),
    .wait_nanoseconds_o (wait_nanoseconds_o),
    .armed_o            (armed_o),
    .fault_o            (fault_o)
  );

  // Shadow copy of the timer configuration and state.
  logic             shadow_enable = 1'b0;
  logic [SEC_W-1:0] shadow_dly_s = '0;
  logic [NS_W-1:0]  shadow_dly_ns = '0;
  logic [NS_W-1:0]  shadow_offset = '0;
  logic [SEC_W-1:0] shadow_ivl_s = 32'd1;
  logic [NS_W-1:0]  shadow_ivl_ns = '0;
  logic [63:0]      fire_time = '0;
  logic             fire_armed = 1'b0;

  deadline_wait_t pending_waits[$];
  int unsigned    err_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    random_items = 0;
  logic           quiet = 1'b0;
  logic           hold_req = 1'b0;

  dir_row_t dir_rows [29] = '{
    '{1'b0, CFG_ENABLE, 32'd0, OP_TIMEOUT, 32'd0, 30'd0, 1'b1, '{32'd0, 30'd0, 1'b0, 1'b0}},
    '{1'b0, CFG_ENABLE, 32'd0, OP_ARM, 32'd12, 30'd345, 1'b1, '{32'd0, 30'd0, 1'b0, 1'b0}},
    '{1'b1, CFG_ENABLE, 32'd1, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLE, 32'd0, OP_TIMEOUT, 32'd7, 30'd0, 1'b1, '{32'd0, 30'd0, 1'b0, 1'b1}},
    '{1'b0, CFG_ENABLE, 32'd0, OP_ARM, 32'd0, 30'd0, 1'b1, '{32'd0, 30'd0, 1'b1, 1'b0}},
    '{1'b0, CFG_ENABLE, 32'd0, OP_TIMEOUT, 32'd0, 30'd0, 1'b1, '{32'd1, 30'd0, 1'b1, 1'b0}},
    '{1'b0, CFG_ENABLE, 32'd0, OP_TIMEOUT, 32'd5, 30'd250000000, 1'b1,
      '{32'd0, 30'd750000000, 1'b1, 1'b0}},
    '{1'b1, CFG_OFFSET, 32'd999999999, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLE, 32'd0, OP_ARM, SEC_MAX, 30'h3FFF_FFFF, 1'b0, '0},
    '{1'b0, CFG_ENABLE, 32'd0, OP_TIMEOUT, 32'd0, 30'd0, 1'b1, '{SEC_MAX, NS_MAX, 1'b1, 1'b0}},
    '{1'b1, CFG_DLY_S, 32'hFFFF_FFFF, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b1, CFG_DLY_NS, 32'd999999999, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLE, 32'd0, OP_ARM, 32'd0, 30'd0, 1'b1, '{SEC_MAX, NS_MAX, 1'b1, 1'b0}},
    '{1'b1, CFG_IVL_S, 32'd0, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLE, 32'd0, OP_TIMEOUT, SEC_MAX, 30'h3FFF_FFFF, 1'b1,
      '{32'd0, 30'd0, 1'b1, 1'b1}},
    '{1'b1, CFG_IVL_NS, 32'h3FFF_FFFF, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLE, 32'd0, OP_TIMEOUT, SEC_MAX, 30'h3FFF_FFFF, 1'b0, '0},
    '{1'b1, CFG_IVL_S, 32'hFFFF_FFFF, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLE, 32'd0, OP_TIMEOUT, SEC_MAX, 30'h3FFF_FFFF, 1'b0, '0},
    '{1'b1, CFG_OFFSET, 32'd0, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b1, CFG_DLY_S, 32'd0, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b1, CFG_DLY_NS, 32'hFFFF_FFFF, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLE, 32'd0, OP_ARM, 32'd3, 30'd999999999, 1'b0, '0},
    '{1'b1, CFG_ENABLE, 32'hFFFF_FFFE, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b1, CFG_ENABLE, 32'd1, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLE, 32'd0, OP_TIMEOUT, 32'd1, 30'd1, 1'b1, '{32'd0, 30'd0, 1'b0, 1'b1}},
    '{1'b0, CFG_ENABLE, 32'd0, OP_ARM, 32'd1, 30'd1, 1'b0, '0},
    '{1'b1, CFG_UNUSED, 32'hFFFF_FFFF, OP_ARM, 32'd0, 30'd0, 1'b0, '0},
    '{1'b0, CFG_ENABLE, 32'd0, OP_TIMEOUT, 32'd9, 30'd500000000, 1'b0, '0}
  };

  function automatic deadline_wait_t split_wait(logic [63:0] wait_total);
    deadline_wait_t r;
    logic [63:0]    secs;
    logic [63:0]    rem;
    r = '0;
    secs = wait_total / NS_PER_S;
    rem = wait_total % NS_PER_S;
    if (secs > {32'd0, SEC_MAX}) begin
      r.wait_s = SEC_MAX;
      r.wait_ns = NS_MAX;
    end else begin
      r.wait_s = secs[SEC_W-1:0];
      r.wait_ns = rem[NS_W-1:0];
    end
    return r;
  endfunction

  // Expected result of one transfer; updates the shadow arm state.
  function automatic deadline_wait_t calc_deadline_wait(op_e op, logic [SEC_W-1:0] sec,
                                                        logic [NS_W-1:0] ns);
    deadline_wait_t r;
    logic [63:0]    now_t;
    logic [63:0]    base;
    logic [63:0]    whole;
    logic [63:0]    period;
    r = '0;
    now_t = {32'd0, sec} * NS_PER_S + {34'd0, ns};
    if (!shadow_enable) begin
      fire_armed = 1'b0;
      return r;
    end
    if (op == OP_ARM) begin
      base = now_t + {32'd0, shadow_dly_s} * NS_PER_S + {34'd0, shadow_dly_ns};
      whole = base / NS_PER_S;
      // Past the offset within this second: the first firing moves to the next second.
      if ((base % NS_PER_S) > {34'd0, shadow_offset}) whole = whole + 64'd1;
      fire_time = whole * NS_PER_S + {34'd0, shadow_offset};
      fire_armed = 1'b1;
      r = split_wait(fire_time - now_t);
      r.armed = 1'b1;
      return r;
    end
    if (!fire_armed) begin
      r.fault = 1'b1;
      return r;
    end
    if (now_t < fire_time) begin
      r = split_wait(fire_time - now_t);
      r.armed = 1'b1;
      return r;
    end
    period = {32'd0, shadow_ivl_s} * NS_PER_S + {34'd0, shadow_ivl_ns};
    if (period == 64'd0) begin
      r.armed = 1'b1;
      r.fault = 1'b1;
      return r;
    end
    r = split_wait(period - ((now_t - fire_time) % period));
    r.armed = 1'b1;
    return r;
  endfunction

  function automatic logic [SEC_W-1:0] pick_sec();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SEC_MAX;
      2, 3: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [NS_W-1:0] pick_ns();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return NS_MAX;
      2: return raw[NS_W-1:0];
      default: return $urandom_range(0, 999999999);
    endcase
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_waits.size() != 0) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_ENABLE: begin
        shadow_enable = data[0];
        if (!data[0]) fire_armed = 1'b0;
      end
      CFG_DLY_S:  shadow_dly_s = data;
      CFG_DLY_NS: shadow_dly_ns = data[NS_W-1:0];
      CFG_OFFSET: shadow_offset = data[NS_W-1:0];
      CFG_IVL_S:  shadow_ivl_s = data;
      CFG_IVL_NS: shadow_ivl_ns = data[NS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_item(op_e op, logic [SEC_W-1:0] sec, logic [NS_W-1:0] ns,
                           logic typed, deadline_wait_t want);
    deadline_wait_t res;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    operation_i = op;
    now_seconds_i = sec;
    now_nanoseconds_i = ns;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = calc_deadline_wait(op, sec, ns);
    if (typed) res = want;
    pending_waits.insert(pending_waits.size(), res);
  endtask

  task automatic idle_input(int unsigned cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none near the end.
  initial begin : result_stall
    int unsigned stall_left;
    logic        hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 5);
        out_stall_i = (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    deadline_wait_t got;
    deadline_wait_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{wait_seconds_o, wait_nanoseconds_o, armed_o, fault_o};
      if (pending_waits.size() == 0) begin
        $display("%0t: unexpected transfer: wait %0d s %0d ns armed %0b fault %0b",
                 $time, got.wait_s, got.wait_ns, got.armed, got.fault);
        err_count++;
      end else begin
        want = pending_waits.pop_front();
        if (got !== want) begin
          $display("%0t: expected %0d s %0d ns armed %0b fault %0b,",
                   $time, want.wait_s, want.wait_ns, want.armed, want.fault,
                   " got %0d s %0d ns armed %0b fault %0b",
                   got.wait_s, got.wait_ns, got.armed, got.fault);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [63:0]      cur_t;
    logic [63:0]      prev_t;
    logic [63:0]      delta;
    logic [63:0]      period;
    logic [63:0]      secs;
    logic [63:0]      rem;
    logic [SEC_W-1:0] sec_v;
    logic [NS_W-1:0]  ns_v;
    logic [CFG_W-1:0] data;
    op_e              op_v;
    int unsigned      phase;
    int unsigned      n_items;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ENABLE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = OP_ARM;
    now_seconds_i = '0;
    now_nanoseconds_i = '0;
    phase = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].sec, dir_rows[i].ns, dir_rows[i].typed,
                  dir_rows[i].want);
        if ($urandom_range(0, 2) == 0) idle_input($urandom_range(1, 5));
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      phase++;
      // Each phase starts from an idle unit with a fresh timer setting.
      write_reg(CFG_DLY_S, ($urandom_range(0, 7) == 0) ? pick_sec() : $urandom_range(0, 2));
      data = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      data[NS_W-1:0] = pick_ns();
      write_reg(CFG_DLY_NS, data);
      data = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      data[NS_W-1:0] = pick_ns();
      write_reg(CFG_OFFSET, data);
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_IVL_S, '0);
        write_reg(CFG_IVL_NS, '0);
      end else begin
        write_reg(CFG_IVL_S, ($urandom_range(0, 5) == 0) ? pick_sec() : $urandom_range(0, 3));
        data = ($urandom_range(0, 3) == 0) ? $urandom : '0;
        data[NS_W-1:0] = pick_ns();
        write_reg(CFG_IVL_NS, data);
      end
      data = $urandom;
      data[0] = ($urandom_range(0, 9) != 0);
      write_reg(CFG_ENABLE, data);
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, $urandom);

      period = {32'd0, shadow_ivl_s} * NS_PER_S + {34'd0, shadow_ivl_ns};
      cur_t = {32'd0, pick_sec()} * NS_PER_S + $urandom_range(0, 999999999);
      if (phase == 3) hold_req = 1'b1;
      n_items = $urandom_range(30, 80);

      for (int unsigned k = 0; k < n_items && random_items < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          op_v = ($urandom_range(0, 1) == 1) ? OP_TIMEOUT : OP_ARM;
          sec_v = $urandom;
          data = $urandom;
          ns_v = data[NS_W-1:0];
        end else begin
          if (k == 0)
            op_v = ($urandom_range(0, 4) == 0) ? OP_TIMEOUT : OP_ARM;
          else
            op_v = ($urandom_range(0, 9) == 0) ? OP_ARM : OP_TIMEOUT;
          if (k != 0) begin
            prev_t = cur_t;
            case ($urandom_range(0, 5))
              0: delta = '0;
              1: delta = $urandom_range(0, 999);
              2: delta = {32'd0, $urandom};
              // Land on, just before or just after a whole number of periods past the last instant.
              3: delta = (period == 0) ? 64'd1 :
                         period * $urandom_range(1, 3) + $urandom_range(0, 2) - 64'd1;
              4: delta = {$urandom, $urandom} >> $urandom_range(16, 40);
              default: delta = $urandom_range(0, 3) * NS_PER_S;
            endcase
            cur_t = prev_t + delta;
            if (cur_t < prev_t || (cur_t / NS_PER_S) > {32'd0, SEC_MAX})
              cur_t = {32'd0, $urandom};
          end
          secs = cur_t / NS_PER_S;
          rem = cur_t % NS_PER_S;
          sec_v = secs[SEC_W-1:0];
          ns_v = rem[NS_W-1:0];
          // Same instant written with a nanosecond part of a second or more.
          if ($urandom_range(0, 7) == 0 && sec_v != 0 && ns_v < 30'd73741824) begin
            sec_v = sec_v - 32'd1;
            ns_v = ns_v + 30'd1000000000;
          end
        end
        send_item(op_v, sec_v, ns_v, 1'b0, '0);
        random_items++;
        quiet = (random_items >= QUIET_AFTER);
        if (!quiet && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 5));
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_waits.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
